FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, muted while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tdma_wl_pkg.sv
`timescale 1ns / 1ps

package tdma_wl_pkg;

  // Event codes
  localparam logic [3:0] EV_ARM       = 4'd0;
  localparam logic [3:0] EV_RESET     = 4'd1;
  localparam logic [3:0] EV_CLK_START = 4'd2;
  localparam logic [3:0] EV_RX_START  = 4'd3;
  localparam logic [3:0] EV_CLK_DONE  = 4'd4;
  localparam logic [3:0] EV_RX_DONE   = 4'd5;
  localparam logic [3:0] EV_STOP      = 4'd6;
  localparam logic [3:0] EV_NEXT      = 4'd7;
  localparam logic [3:0] EV_ERROR     = 4'd8;

  // Mode codes
  localparam logic [2:0] MODE_STOPPED  = 3'd0;
  localparam logic [2:0] MODE_ARMED    = 3'd1;
  localparam logic [2:0] MODE_RUNNING  = 3'd2;
  localparam logic [2:0] MODE_BOUNDARY = 3'd3;
  localparam logic [2:0] MODE_FAULT    = 3'd4;

  // Error codes
  localparam logic [31:0] ERR_NONE      = 32'd0;
  localparam logic [31:0] ERR_RUNTIME   = 32'd1;
  localparam logic [31:0] ERR_CLK_AGAIN = 32'd2;
  localparam logic [31:0] ERR_RX_AGAIN  = 32'd3;
  localparam logic [31:0] ERR_CLK_NOST  = 32'd4;
  localparam logic [31:0] ERR_RX_NOST   = 32'd5;
  localparam logic [31:0] ERR_INVALID   = 32'd6;

  // Activity flags
  typedef struct packed {
    logic clk_busy;
    logic rx_busy;
    logic clk_done;
    logic rx_done;
  } flags_t;

  // Outcome of one event, from the decoder to the state registers
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] err;
    flags_t      flags;
    logic        accepted;
    logic        inc_trans;
    logic        inc_window;
    logic        inc_finished;
    logic        clear_counts;
  } ctl_t;

endpackage

FILE: design/tdma_wl_next.sv
`timescale 1ns / 1ps

module tdma_wl_next (
  input  logic                  [2:0]  mode,
  input  tdma_wl_pkg::flags_t          flags,
  input  logic                  [3:0]  req_type,
  input  logic                  [31:0] error_value,
  output tdma_wl_pkg::ctl_t            ctl
);

  tdma_wl_pkg::flags_t f;

  always_comb begin
    f = flags;
    ctl              = '0;
    ctl.mode         = mode;
    ctl.flags        = flags;
    ctl.accepted     = 1'b1;
    ctl.inc_trans    = 1'b1;
    ctl.err          = tdma_wl_pkg::ERR_NONE;

    if (req_type == tdma_wl_pkg::EV_ERROR) begin
      // error event: enter fault from anywhere
      ctl.flags.clk_busy = 1'b0;
      ctl.flags.rx_busy  = 1'b0;
      ctl.mode = tdma_wl_pkg::MODE_FAULT;
      ctl.err  = (error_value == 32'd0) ? tdma_wl_pkg::ERR_RUNTIME : error_value;
    end else if (req_type == tdma_wl_pkg::EV_RESET) begin
      // reset event: clear everything, count nothing
      ctl.flags        = '0;
      ctl.mode         = tdma_wl_pkg::MODE_STOPPED;
      ctl.inc_trans    = 1'b0;
      ctl.clear_counts = 1'b1;
    end else begin
      // default outcome: invalid transition
      ctl.accepted       = 1'b0;
      ctl.mode           = tdma_wl_pkg::MODE_FAULT;
      ctl.err            = tdma_wl_pkg::ERR_INVALID;
      ctl.flags.clk_busy = 1'b0;
      ctl.flags.rx_busy  = 1'b0;
      case (mode)
        tdma_wl_pkg::MODE_STOPPED: begin
          if (req_type == tdma_wl_pkg::EV_ARM) begin
            ctl.accepted   = 1'b1;
            ctl.mode       = tdma_wl_pkg::MODE_ARMED;
            ctl.err        = tdma_wl_pkg::ERR_NONE;
            ctl.flags      = '0;
            ctl.inc_window = 1'b1;
          end
        end
        tdma_wl_pkg::MODE_ARMED, tdma_wl_pkg::MODE_RUNNING: begin
          case (req_type)
            tdma_wl_pkg::EV_CLK_START: begin
              if (flags.clk_busy || flags.clk_done) begin
                ctl.err = tdma_wl_pkg::ERR_CLK_AGAIN;
              end else begin
                f.clk_busy   = 1'b1;
                ctl.flags    = f;
                ctl.accepted = 1'b1;
                ctl.mode     = tdma_wl_pkg::MODE_RUNNING;
                ctl.err      = tdma_wl_pkg::ERR_NONE;
              end
            end
            tdma_wl_pkg::EV_RX_START: begin
              if (flags.rx_busy || flags.rx_done) begin
                ctl.err = tdma_wl_pkg::ERR_RX_AGAIN;
              end else begin
                f.rx_busy    = 1'b1;
                ctl.flags    = f;
                ctl.accepted = 1'b1;
                ctl.mode     = tdma_wl_pkg::MODE_RUNNING;
                ctl.err      = tdma_wl_pkg::ERR_NONE;
              end
            end
            tdma_wl_pkg::EV_CLK_DONE: begin
              if (!flags.clk_busy || (!flags.rx_busy && !flags.rx_done)) begin
                ctl.err = tdma_wl_pkg::ERR_CLK_NOST;
              end else begin
                f.clk_busy   = 1'b0;
                f.clk_done   = 1'b1;
                ctl.flags    = f;
                ctl.accepted = 1'b1;
                ctl.err      = tdma_wl_pkg::ERR_NONE;
                ctl.inc_finished = f.rx_done;
                ctl.mode = f.rx_done ? tdma_wl_pkg::MODE_BOUNDARY
                                     : tdma_wl_pkg::MODE_RUNNING;
              end
            end
            tdma_wl_pkg::EV_RX_DONE: begin
              if (!flags.rx_busy || (!flags.clk_busy && !flags.clk_done)) begin
                ctl.err = tdma_wl_pkg::ERR_RX_NOST;
              end else begin
                f.rx_busy    = 1'b0;
                f.rx_done    = 1'b1;
                ctl.flags    = f;
                ctl.accepted = 1'b1;
                ctl.err      = tdma_wl_pkg::ERR_NONE;
                ctl.inc_finished = f.clk_done;
                ctl.mode = f.clk_done ? tdma_wl_pkg::MODE_BOUNDARY
                                      : tdma_wl_pkg::MODE_RUNNING;
              end
            end
            tdma_wl_pkg::EV_STOP: begin
              ctl.accepted = 1'b1;
              ctl.mode     = tdma_wl_pkg::MODE_STOPPED;
              ctl.err      = tdma_wl_pkg::ERR_NONE;
              ctl.flags    = '0;
            end
            default: begin
            end
          endcase
        end
        tdma_wl_pkg::MODE_BOUNDARY: begin
          if (req_type == tdma_wl_pkg::EV_NEXT) begin
            ctl.accepted   = 1'b1;
            ctl.mode       = tdma_wl_pkg::MODE_RUNNING;
            ctl.err        = tdma_wl_pkg::ERR_NONE;
            ctl.flags      = '0;
            ctl.inc_window = 1'b1;
          end else if (req_type == tdma_wl_pkg::EV_STOP) begin
            ctl.accepted = 1'b1;
            ctl.mode     = tdma_wl_pkg::MODE_STOPPED;
            ctl.err      = tdma_wl_pkg::ERR_NONE;
            ctl.flags    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/tdma_window_lifecycle_fsm.sv
`timescale 1ns / 1ps
// TDMA window lifecycle controller.
// Input channel: in_valid / in_stall carry one event (in_req_type) with an
// optional error code (in_error_value). Result channel: out_valid / out_stall
// carry the outcome of that event: accepted flag, mode after the event, last
// error code, the transition / window / finished-window totals and the four
// activity flags.
// An event's result shows on the out_ ports once it has passed the input
// register and then the result register (one input register, one result register).
// Throughput: one event per cycle while the receiver does not stall; the mode, flags
// and counters update in a single pass through the event decoder as the event leaves the input register.
// Reset (rst_n low, synchronous) empties both registers and sets mode stopped,
// no error, zero counters and all flags clear. A reset event on the input
// channel does the same to the state and still produces a result item.
// When the receiver stalls, the result register holds; one more event may
// still enter the input register, after which in_stall rises until the
// result is taken.
module tdma_window_lifecycle_fsm #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_req_type,
  input  logic [31:0] in_error_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [2:0]  out_mode,
  output logic [31:0] out_error_code,
  output logic [31:0] out_transition_total,
  output logic [31:0] out_window_total,
  output logic [31:0] out_finished_total,
  output logic        out_clk_busy,
  output logic        out_rx_busy,
  output logic        out_clk_done,
  output logic        out_rx_done
);

  `include "assert_macros.svh"

  // Input register
  logic        in_valid_r;
  logic [3:0]  req_type_r;
  logic [31:0] error_value_r;

  // Block state
  logic [2:0]             mode_r,  mode_nxt;
  logic [31:0]            err_r,   err_nxt;
  tdma_wl_pkg::flags_t    flags_r, flags_nxt;
  logic [COUNT_WIDTH-1:0] trans_r, trans_nxt;
  logic [COUNT_WIDTH-1:0] win_r,   win_nxt;
  logic [COUNT_WIDTH-1:0] fin_r,   fin_nxt;

  // Result register
  logic out_valid_r;
  logic accepted_r;

  tdma_wl_pkg::ctl_t ctl;
  logic              out_free;
  logic              advance;

  // Pipeline handshake
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  tdma_wl_next u_next (
    .mode        (mode_r),
    .flags       (flags_r),
    .req_type    (req_type_r),
    .error_value (error_value_r),
    .ctl         (ctl)
  );

  // Apply the decoded outcome
  always_comb begin
    mode_nxt  = ctl.mode;
    err_nxt   = ctl.err;
    flags_nxt = ctl.flags;
    if (ctl.clear_counts) begin
      trans_nxt = '0;
      win_nxt   = '0;
      fin_nxt   = '0;
    end else begin
      trans_nxt = trans_r + COUNT_WIDTH'(ctl.inc_trans);
      win_nxt   = win_r + COUNT_WIDTH'(ctl.inc_window);
      fin_nxt   = fin_r + COUNT_WIDTH'(ctl.inc_finished);
    end
  end

  // Load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      req_type_r    <= in_req_type;
      error_value_r <= in_error_value;
    end
  end

  // Advance state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      accepted_r  <= 1'b0;
      mode_r      <= tdma_wl_pkg::MODE_STOPPED;
      err_r       <= tdma_wl_pkg::ERR_NONE;
      flags_r     <= '0;
      trans_r     <= '0;
      win_r       <= '0;
      fin_r       <= '0;
    end else begin
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        accepted_r <= ctl.accepted;
        mode_r     <= mode_nxt;
        err_r      <= err_nxt;
        flags_r    <= flags_nxt;
        trans_r    <= trans_nxt;
        win_r      <= win_nxt;
        fin_r      <= fin_nxt;
      end
    end
  end

  // Results come straight from the state registers
  assign out_valid            = out_valid_r;
  assign out_accepted         = accepted_r;
  assign out_mode             = mode_r;
  assign out_error_code       = err_r;
  assign out_transition_total = 32'(trans_r);
  assign out_window_total     = 32'(win_r);
  assign out_finished_total   = 32'(fin_r);
  assign out_clk_busy         = flags_r.clk_busy;
  assign out_rx_busy          = flags_r.rx_busy;
  assign out_clk_done         = flags_r.clk_done;
  assign out_rx_done          = flags_r.rx_done;

  `ASSERT_CLK(a_fault_idle, (mode_r == tdma_wl_pkg::MODE_FAULT) |-> (!flags_r.clk_busy && !flags_r.rx_busy), "busy flag set in fault mode")
  `ASSERT_CLK(a_reject_fault, (out_valid_r && !accepted_r) |-> (mode_r == tdma_wl_pkg::MODE_FAULT), "rejected event outside fault mode")
  `ASSERT_CLK(a_clk_excl, !(flags_r.clk_busy && flags_r.clk_done), "clock transmit both busy and done")
  `ASSERT_CLK(a_rx_excl, !(flags_r.rx_busy && flags_r.rx_done), "data receive both busy and done")
  `ASSERT_ALWAYS(a_stall_full, in_stall |-> in_valid_r, "input stalled with empty input register")

endmodule
